/* hdl/slab_object_allocator_assert.svh */
// Assertion macros for the slab allocator, included by its top-level source.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef SLAB_OBJECT_ALLOCATOR_ASSERT_SVH
`define SLAB_OBJECT_ALLOCATOR_ASSERT_SVH

// Checks that a condition holds at every clock edge.
`define SOA_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("slab allocator check failed");

// Checks that a trigger is followed by a consequence in the next cycle.
`define SOA_ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error("slab allocator sequence check failed");

`endif

/* hdl/soa_pkg.sv */
package soa_pkg;

  localparam int unsigned MaxSlabs    = 16;
  localparam int unsigned SlabBytes   = 32768;
  localparam int unsigned HeaderBytes = 48;
  localparam int unsigned MaxObjects  = 2048;
  localparam int unsigned AlignBytes  = 16;
  localparam int unsigned MinObject   = 16;

  localparam int unsigned AddrW  = 19;
  localparam int unsigned SizeW  = 15;
  localparam int unsigned SlabW  = $clog2(MaxSlabs);
  localparam int unsigned SlabCw = SlabW + 1;
  localparam int unsigned ObjW   = $clog2(MaxObjects);
  localparam int unsigned ObjCw  = ObjW + 1;
  localparam int unsigned OffW   = $clog2(SlabBytes);
  localparam int unsigned SlotW  = SlabW + ObjW;
  localparam int unsigned AlignSh = $clog2(AlignBytes);
  // Effective size reaches SIZE_MAX rounded up, which needs one bit more.
  localparam int unsigned EffW   = SizeW + 1;
  localparam int unsigned UnitW  = EffW - AlignSh;
  localparam int unsigned DivW   = OffW;

  localparam logic [DivW-1:0]   PerSlabNum = DivW'(SlabBytes - HeaderBytes);
  localparam logic [SlabCw-1:0] NoSlab     = SlabCw'(MaxSlabs);
  localparam logic [ObjCw-1:0]  NoObject   = ObjCw'(MaxObjects);

  localparam logic ModeAlloc = 1'b0;
  localparam logic ModeFree  = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_SLAB = 2'd1,
    STAT_FOREIGN = 2'd2,
    STAT_DOUBLE  = 2'd3
  } status_e;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quot;
    logic [EffW-1:0] rem;
  } div_res_t;

  typedef struct packed {
    logic             link_we;
    logic             taken_we;
    logic [SlotW-1:0] waddr;
    logic [ObjCw-1:0] link_wdata;
    logic             taken_wdata;
    logic [SlotW-1:0] raddr;
  } store_req_t;

endpackage

/* hdl/soa_divider.sv */
module soa_divider import soa_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [EffW-1:0] divisor_i,
  output div_res_t        res_o
);

  localparam int unsigned CntW = $clog2(DivW);

  logic [DivW-1:0] quot_q;
  logic [EffW-1:0] rem_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [EffW:0]   shifted, diff;
  logic            fits;

  // Restoring division: one quotient bit per cycle, dividend shifted in from the top.
  assign shifted = {rem_q, quot_q[DivW-1]};
  assign diff    = shifted - {1'b0, divisor_i};
  assign fits    = shifted >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(DivW - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      quot_q <= {quot_q[DivW-2:0], fits};
      rem_q  <= fits ? diff[EffW-1:0] : shifted[EffW-1:0];
    end
  end

  assign res_o.done = done_q;
  assign res_o.quot = quot_q;
  assign res_o.rem  = rem_q;

endmodule

/* hdl/soa_obj_store.sv */
module soa_obj_store import soa_pkg::*; (
  input  logic             clk_i,
  input  store_req_t       req_i,
  output logic [ObjCw-1:0] link_rdata_o,
  output logic             taken_rdata_o
);

  localparam int unsigned Depth = MaxSlabs * MaxObjects;

  logic [ObjCw-1:0] link_mem  [Depth];
  logic             taken_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (req_i.link_we) begin
      link_mem[req_i.waddr] <= req_i.link_wdata;
    end
    link_rdata_o <= link_mem[req_i.raddr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.taken_we) begin
      taken_mem[req_i.waddr] <= req_i.taken_wdata;
    end
    taken_rdata_o <= taken_mem[req_i.raddr];
  end

endmodule

/* hdl/slab_object_allocator.sv */
// Slab object allocator. Each request is an allocate or a free and yields one
// response. Requests are handled one at a time; s_axis_tready is high only while
// the sequencer is idle. Every request first divides the usable slab bytes by
// the effective object size on a shared 15-step serial divider. A successful
// allocate passes ALLOC, ALLOC_POP, ALLOC_LINK when it pops a returned object
// and ALLOC_FIN on its way to OUT; a failed allocate leaves ALLOC or ALLOC_POP
// for OUT. A free runs FREE_CHK, then DIV2, a second divider pass splitting
// the slab offset into an object index, then FREE_TAKEN; a foreign one leaves
// at FREE_CHK or DIV2. The sequencer waits in its output state while an earlier
// response is held by m_axis_tready low. Per-object links and taken flags live
// in a single-port-write memory with registered reads, so no clearing pass is
// needed after reset or a size write. Writing cfg_wdata_i empties the allocator
// and must happen only while it is idle.
`include "slab_object_allocator_assert.svh"

module slab_object_allocator import soa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SizeW-1:0] cfg_wdata_i,   // object_size
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [23:0]      s_axis_tdata,  // [18:0] address
  input  logic [0:0]       s_axis_tuser,  // [0] mode
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // [18:0] object_address
  output logic [1:0]       m_axis_tuser   // [1:0] status
);

  localparam logic [3:0] ST_IDLE       = 4'd0;
  localparam logic [3:0] ST_DIV1       = 4'd1;
  localparam logic [3:0] ST_ALLOC      = 4'd2;
  localparam logic [3:0] ST_ALLOC_POP  = 4'd3;
  localparam logic [3:0] ST_ALLOC_LINK = 4'd4;
  localparam logic [3:0] ST_ALLOC_FIN  = 4'd5;
  localparam logic [3:0] ST_FREE_CHK   = 4'd6;
  localparam logic [3:0] ST_DIV2       = 4'd7;
  localparam logic [3:0] ST_FREE_TAKEN = 4'd8;
  localparam logic [3:0] ST_OUT        = 4'd9;

  logic [3:0]       state_q, state_d;
  logic [SizeW-1:0] size_q;
  logic [SlabCw-1:0] opened_q, opened_d, top_q, top_d;
  logic             mode_q;
  logic [AddrW-1:0] addr_q;
  logic [SlabW-1:0] slab_q, slab_d;
  logic [ObjW-1:0]  obj_q, obj_d;
  logic [ObjCw-1:0] cnt_q, cnt_d;
  status_e          res_stat_q, res_stat_d;
  logic [AddrW-1:0] res_addr_q, res_addr_d;
  logic             out_valid_q;

  logic [ObjCw-1:0]  head_q  [MaxSlabs];
  logic [ObjCw-1:0]  fresh_q [MaxSlabs];
  logic [SlabCw-1:0] plink_q [MaxSlabs];

  logic              ps_we;
  logic [SlabW-1:0]  ps_idx;
  logic              head_we, fresh_we, plink_we;
  logic [ObjCw-1:0]  head_wd, fresh_wd;
  logic [SlabCw-1:0] plink_wd;

  logic             accept;
  logic [UnitW-1:0] size_units;
  logic [EffW-1:0]  eff_size;
  logic [OffW-1:0]  offset, rel;
  logic [SlabW-1:0] addr_slab;
  logic             div_start;
  logic [DivW-1:0]  div_dividend;
  div_res_t         div_res;
  store_req_t       st_req;
  logic [ObjCw-1:0] link_rdata;
  logic             taken_rdata;
  logic [ObjCw-1:0] cur_head, cur_fresh;
  logic [SlabCw-1:0] cur_plink;
  logic [ObjW+EffW-1:0] obj_bytes;
  logic             slab_full;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  // Round up to the alignment, with a floor at the minimum object size.
  always_comb begin
    logic [SizeW:0] sum;
    sum = {1'b0, size_q} + (SizeW + 1)'(AlignBytes - 1);
    if (size_q < SizeW'(MinObject)) begin
      size_units = UnitW'(MinObject / AlignBytes);
    end else begin
      size_units = sum[SizeW:AlignSh];
    end
  end
  assign eff_size = {size_units, AlignSh'(0)};

  assign addr_slab = addr_q[AddrW-1:OffW];
  assign offset    = addr_q[OffW-1:0];
  assign rel       = offset - OffW'(HeaderBytes);

  assign cur_head  = head_q[slab_q];
  assign cur_fresh = fresh_q[slab_q];
  assign cur_plink = plink_q[slab_q];
  assign slab_full = (cur_head >= NoObject) && (cur_fresh == '0);
  assign obj_bytes = obj_q * eff_size;

  assign div_dividend = (state_q == ST_IDLE) ? PerSlabNum : rel;

  soa_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (eff_size),
    .res_o      (div_res)
  );

  soa_obj_store u_store (
    .clk_i         (clk_i),
    .req_i         (st_req),
    .link_rdata_o  (link_rdata),
    .taken_rdata_o (taken_rdata)
  );

  always_comb begin
    state_d    = state_q;
    opened_d   = opened_q;
    top_d      = top_q;
    slab_d     = slab_q;
    obj_d      = obj_q;
    cnt_d      = cnt_q;
    res_stat_d = res_stat_q;
    res_addr_d = res_addr_q;
    div_start  = 1'b0;
    ps_we      = 1'b0;
    ps_idx     = slab_q;
    head_we    = 1'b0;
    fresh_we   = 1'b0;
    plink_we   = 1'b0;
    head_wd    = cur_head;
    fresh_wd   = cur_fresh;
    plink_wd   = cur_plink;
    st_req.link_we     = 1'b0;
    st_req.taken_we    = 1'b0;
    st_req.waddr       = {slab_q, obj_q};
    st_req.link_wdata  = cur_head;
    st_req.taken_wdata = 1'b0;
    st_req.raddr       = {slab_q, obj_q};

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          div_start = 1'b1;
          state_d   = ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (div_res.done) begin
          if (div_res.quot > DivW'(MaxObjects)) begin
            cnt_d = NoObject;
          end else begin
            cnt_d = div_res.quot[ObjCw-1:0];
          end
          state_d = (mode_q == ModeAlloc) ? ST_ALLOC : ST_FREE_CHK;
        end
      end
      ST_ALLOC: begin
        res_addr_d = '0;
        if (cnt_q == '0) begin
          res_stat_d = STAT_NO_SLAB;
          state_d    = ST_OUT;
        end else if (top_q >= NoSlab) begin
          if (opened_q >= NoSlab) begin
            res_stat_d = STAT_NO_SLAB;
            state_d    = ST_OUT;
          end else begin
            // Open the next unused slab and make it the only partial slab.
            ps_idx   = opened_q[SlabW-1:0];
            head_we  = 1'b1;
            head_wd  = NoObject;
            fresh_we = 1'b1;
            fresh_wd = cnt_q;
            plink_we = 1'b1;
            plink_wd = NoSlab;
            top_d    = opened_q;
            opened_d = opened_q + 1'b1;
            slab_d   = opened_q[SlabW-1:0];
            state_d  = ST_ALLOC_POP;
          end
        end else begin
          slab_d  = top_q[SlabW-1:0];
          state_d = ST_ALLOC_POP;
        end
      end
      ST_ALLOC_POP: begin
        if (cur_head < NoObject) begin
          obj_d        = cur_head[ObjW-1:0];
          st_req.raddr = {slab_q, cur_head[ObjW-1:0]};
          state_d      = ST_ALLOC_LINK;
        end else if (cur_fresh != '0 && cur_fresh <= NoObject) begin
          fresh_we = 1'b1;
          fresh_wd = cur_fresh - 1'b1;
          obj_d    = fresh_wd[ObjW-1:0];
          state_d  = ST_ALLOC_FIN;
        end else begin
          res_stat_d = STAT_NO_SLAB;
          state_d    = ST_OUT;
        end
      end
      ST_ALLOC_LINK: begin
        head_we = 1'b1;
        head_wd = link_rdata;
        state_d = ST_ALLOC_FIN;
      end
      ST_ALLOC_FIN: begin
        st_req.taken_we    = 1'b1;
        st_req.taken_wdata = 1'b1;
        if (slab_full) begin
          top_d = cur_plink;
        end
        res_addr_d = AddrW'({slab_q, OffW'(0)}) + AddrW'(HeaderBytes) + obj_bytes[AddrW-1:0];
        res_stat_d = STAT_OK;
        state_d    = ST_OUT;
      end
      ST_FREE_CHK: begin
        res_addr_d = '0;
        slab_d     = addr_slab;
        if ({1'b0, addr_slab} >= opened_q || offset < OffW'(HeaderBytes)) begin
          res_stat_d = STAT_FOREIGN;
          state_d    = ST_OUT;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (div_res.done) begin
          if (div_res.rem != '0 || div_res.quot >= DivW'(cnt_q)) begin
            res_stat_d = STAT_FOREIGN;
            state_d    = ST_OUT;
          end else begin
            obj_d        = div_res.quot[ObjW-1:0];
            st_req.raddr = {slab_q, div_res.quot[ObjW-1:0]};
            state_d      = ST_FREE_TAKEN;
          end
        end
      end
      ST_FREE_TAKEN: begin
        if ({1'b0, obj_q} < cur_fresh || !taken_rdata) begin
          res_stat_d = STAT_DOUBLE;
        end else begin
          // Push the object on its slab's returned list.
          st_req.link_we     = 1'b1;
          st_req.link_wdata  = cur_head;
          st_req.taken_we    = 1'b1;
          st_req.taken_wdata = 1'b0;
          head_we = 1'b1;
          head_wd = {1'b0, obj_q};
          if (slab_full) begin
            plink_we = 1'b1;
            plink_wd = top_q;
            top_d    = {1'b0, slab_q};
          end
          res_stat_d = STAT_OK;
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    ps_we = head_we || fresh_we || plink_we;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      size_q      <= SizeW'(64);
      opened_q    <= '0;
      top_q       <= NoSlab;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        size_q   <= cfg_wdata_i;
        opened_q <= '0;
        top_q    <= NoSlab;
      end else begin
        opened_q <= opened_d;
        top_q    <= top_d;
      end
      if (state_q == ST_OUT && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= s_axis_tuser[0];
      addr_q <= s_axis_tdata[AddrW-1:0];
    end
    slab_q     <= slab_d;
    obj_q      <= obj_d;
    cnt_q      <= cnt_d;
    res_stat_q <= res_stat_d;
    res_addr_q <= res_addr_d;
    if (ps_we) begin
      if (head_we) begin
        head_q[ps_idx] <= head_wd;
      end
      if (fresh_we) begin
        fresh_q[ps_idx] <= fresh_wd;
      end
      if (plink_we) begin
        plink_q[ps_idx] <= plink_wd;
      end
    end
  end

  logic [AddrW-1:0] out_addr_q;
  status_e          out_stat_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && (!out_valid_q || m_axis_tready)) begin
      out_addr_q <= res_addr_q;
      out_stat_q <= res_stat_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_addr_q};
  assign m_axis_tuser  = out_stat_q;

  `SOA_ASSERT_ALWAYS(a_top_bounded, top_q == NoSlab || top_q < opened_q)
  `SOA_ASSERT_ALWAYS(a_opened_bounded, opened_q <= NoSlab)
  `SOA_ASSERT_ALWAYS(a_fail_zero_addr, !m_axis_tvalid || m_axis_tuser == STAT_OK || m_axis_tdata == '0)
  `SOA_ASSERT_NEXT(a_busy_after_accept, accept, !s_axis_tready)

endmodule

/* dv/slab_object_allocator_test.sv */
`timescale 1ns / 1ps

module slab_object_allocator_test import soa_pkg::*; ();

  localparam int unsigned StallLimit = 5000;

  typedef struct {
    status_e          status;
    logic [AddrW-1:0] obj_addr;
  } alloc_resp_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [SizeW-1:0] cfg_wdata_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [23:0]      s_axis_tdata = '0;   // [18:0] address
  logic [0:0]       s_axis_tuser = '0;   // [0] mode
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [23:0]      m_axis_tdata;        // [18:0] object_address
  logic [1:0]       m_axis_tuser;        // [1:0] status

  slab_object_allocator dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  // Shadow allocator state.
  int unsigned obj_size_cfg = 64;
  int unsigned n_opened;
  int unsigned partial_head = MaxSlabs;
  int unsigned slab_next [MaxSlabs];
  int unsigned free_head [MaxSlabs];
  int unsigned untouched [MaxSlabs];
  int unsigned free_next [MaxSlabs*MaxObjects];
  bit          in_use [MaxSlabs*MaxObjects];

  alloc_resp_t       pending_resp[$];
  logic [AddrW-1:0]  live_objs[$];
  logic [AddrW-1:0]  freed_objs[$];
  int unsigned       fail_cnt;
  int unsigned       quiet_cycles;
  int unsigned       stall_left;
  bit                calm;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned rounded_size();
    int unsigned e;
    e = (obj_size_cfg < MinObject) ? MinObject : obj_size_cfg;
    return (e + AlignBytes - 1) / AlignBytes * AlignBytes;
  endfunction

  function automatic int unsigned slab_capacity();
    int unsigned n;
    n = (SlabBytes - HeaderBytes) / rounded_size();
    return (n > MaxObjects) ? MaxObjects : n;
  endfunction

  task automatic model_request(input bit mode, input int unsigned addr,
                               output alloc_resp_t r);
    int unsigned per, sz, s, i, off, rel;
    bit reopen_slab;
    r.status = STAT_OK;
    r.obj_addr = '0;
    per = slab_capacity();
    sz = rounded_size();
    if (mode == ModeAlloc) begin
      if (per == 0) begin
        r.status = STAT_NO_SLAB;
        return;
      end
      if (partial_head >= MaxSlabs) begin
        if (n_opened >= MaxSlabs) begin
          r.status = STAT_NO_SLAB;
          return;
        end
        s = n_opened++;
        free_head[s] = MaxObjects;
        untouched[s] = per;
        slab_next[s] = MaxSlabs;
        partial_head = s;
      end
      s = partial_head;
      if (free_head[s] < MaxObjects) begin
        i = free_head[s];
        free_head[s] = free_next[s*MaxObjects + i];
      end else if (untouched[s] > 0) begin
        untouched[s]--;
        i = untouched[s];
      end else begin
        r.status = STAT_NO_SLAB;
        return;
      end
      in_use[s*MaxObjects + i] = 1'b1;
      if (free_head[s] >= MaxObjects && untouched[s] == 0) partial_head = slab_next[s];
      r.obj_addr = AddrW'(s*SlabBytes + HeaderBytes + i*sz);
      live_objs.push_back(r.obj_addr);
    end else begin
      s = addr / SlabBytes;
      off = addr % SlabBytes;
      if (s >= n_opened || off < HeaderBytes) begin
        r.status = STAT_FOREIGN;
        return;
      end
      rel = off - HeaderBytes;
      if (rel % sz != 0 || rel / sz >= per) begin
        r.status = STAT_FOREIGN;
        return;
      end
      i = rel / sz;
      if (i < untouched[s] || !in_use[s*MaxObjects + i]) begin
        r.status = STAT_DOUBLE;
        return;
      end
      reopen_slab = (free_head[s] >= MaxObjects && untouched[s] == 0);
      free_next[s*MaxObjects + i] = free_head[s];
      free_head[s] = i;
      in_use[s*MaxObjects + i] = 1'b0;
      if (reopen_slab) begin
        slab_next[s] = partial_head;
        partial_head = s;
      end
      foreach (live_objs[k]) begin
        if (live_objs[k] == addr) begin
          live_objs.delete(k);
          break;
        end
      end
      if (freed_objs.size() < 64) freed_objs.push_back(AddrW'(addr));
    end
  endtask

  task automatic send_request(input bit mode, input int unsigned addr);
    alloc_resp_t r;
    if (!calm && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 7)) @(negedge clk_i);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {5'b0, addr[AddrW-1:0]};
    forever begin
      @(posedge clk_i);
      if (s_axis_tready) break;
    end
    model_request(mode, addr, r);
    pending_resp.push_back(r);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_resp.size() == 0);
    repeat (50) @(posedge clk_i);
  endtask

  // The block must be idle; a size write empties the allocator.
  task automatic set_object_size(input int unsigned sz);
    drain();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= SizeW'(sz);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    obj_size_cfg = sz;
    n_opened = 0;
    partial_head = MaxSlabs;
    live_objs.delete();
    freed_objs.delete();
  endtask

  task automatic test_basic_alloc_free();
    int unsigned a0;
    send_request(ModeAlloc, 0);
    send_request(ModeAlloc, 0);
    send_request(ModeAlloc, 0);
    a0 = live_objs[0];
    send_request(ModeFree, a0);
    send_request(ModeFree, a0);                    // double free
    send_request(ModeFree, HeaderBytes);           // never handed out yet
    send_request(ModeFree, 16);                    // inside the header
    send_request(ModeFree, a0 + 16);               // between objects
    send_request(ModeFree, SlabBytes + HeaderBytes); // slab not opened
    send_request(ModeFree, 19'h7FFFF);
    send_request(ModeFree, SlabBytes - 16);        // past the last object
    send_request(ModeAlloc, 0);                    // reuses the freed object
  endtask

  task automatic test_pool_exhaustion();
    set_object_size(32720);
    repeat (17) send_request(ModeAlloc, 0);
    send_request(ModeFree, 5*SlabBytes + HeaderBytes);
    send_request(ModeFree, 9*SlabBytes + HeaderBytes);
    send_request(ModeAlloc, 0);
    send_request(ModeAlloc, 0);
    send_request(ModeAlloc, 0);
  endtask

  task automatic test_random_mix(input int unsigned sz, input int unsigned count,
                                 input bit hold_mid);
    int unsigned pick, a;
    set_object_size(sz);
    for (int n = 0; n < count; n++) begin
      if (hold_mid && n == count/2) wait (pending_resp.size() == 0);
      pick = $urandom_range(0, 99);
      if (live_objs.size() == 0 || pick < 50) begin
        send_request(ModeAlloc, $urandom);
      end else if (pick < 88) begin
        a = live_objs[$urandom_range(0, live_objs.size() - 1)];
        send_request(ModeFree, a);
      end else if (pick < 93 && freed_objs.size() > 0) begin
        send_request(ModeFree, freed_objs[$urandom_range(0, freed_objs.size() - 1)]);
      end else if (pick < 96) begin
        a = live_objs[$urandom_range(0, live_objs.size() - 1)];
        send_request(ModeFree, (a + 16 * $urandom_range(1, 3)) & 19'h7FFFF);
      end else begin
        send_request(ModeFree, $urandom_range(0, 19'h7FFFF));
      end
    end
  endtask

  // Result side: random stall bursts, none once the run turns calm.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_resp.size() == 0) begin
        $error("response with none outstanding: status %0d", m_axis_tuser);
        fail_cnt++;
      end else begin
        alloc_resp_t e;
        e = pending_resp.pop_front();
        if (m_axis_tuser !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, m_axis_tuser);
          fail_cnt++;
        end
        if (m_axis_tdata[AddrW-1:0] !== e.obj_addr) begin
          $error("object_address: expected %h, got %h", e.obj_addr,
                 m_axis_tdata[AddrW-1:0]);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      quiet_cycles <= 0;
    else if (quiet_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_basic_alloc_free();
    test_pool_exhaustion();
    test_random_mix(4096, 400, 1'b1);
    test_random_mix(1, 300, 1'b0);
    test_random_mix(32720, 200, 1'b0);
    test_random_mix($urandom_range(1, 32720), 250, 1'b0);
    test_random_mix(64, 300, 1'b0);
    calm = 1'b1;
    test_random_mix(2000, 250, 1'b0);
    drain();
    if (fail_cnt == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/soa_pkg.sv
hdl/soa_divider.sv
hdl/soa_obj_store.sv
hdl/slab_object_allocator.sv
dv/slab_object_allocator_test.sv
